// ===== src/e2c_pkg.sv =====
// Shared types, constants, microcode table and calendar helpers for the epoch converter.
package e2c_pkg;

    localparam int SECONDS_WIDTH_DEF = 32;

    localparam int ZONE_W  = 17;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int Y400_W  = 9;
    localparam int STEP_W  = 3;
    localparam int CONST_W = 34;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 12'd1970;
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 12'd4095;
    localparam logic [YEAR_W-1:0] CYCLE_YEARS = 12'd400;
    localparam logic [ZONE_W-1:0] ZONE_RESET  = 17'd28800;

    // position of the year inside its 400-year cycle
    localparam logic [Y400_W-1:0] EPOCH_Y400 = 9'd370;
    localparam logic [Y400_W-1:0] Y400_LAST  = 9'd399;
    localparam logic [Y400_W-1:0] Y400_C100  = 9'd100;
    localparam logic [Y400_W-1:0] Y400_C200  = 9'd200;
    localparam logic [Y400_W-1:0] Y400_C300  = 9'd300;

    localparam logic [CONST_W-1:0] CYCLE_SEC     = 34'd12622780800;
    localparam logic [CONST_W-1:0] YEAR_SEC      = 34'd31536000;
    localparam logic [CONST_W-1:0] LEAP_YEAR_SEC = 34'd31622400;
    localparam logic [CONST_W-1:0] MON31_SEC     = 34'd2678400;
    localparam logic [CONST_W-1:0] MON30_SEC     = 34'd2592000;
    localparam logic [CONST_W-1:0] MON29_SEC     = 34'd2505600;
    localparam logic [CONST_W-1:0] MON28_SEC     = 34'd2419200;
    localparam logic [CONST_W-1:0] DAY_SEC       = 34'd86400;
    localparam logic [CONST_W-1:0] HOUR_SEC      = 34'd3600;
    localparam logic [CONST_W-1:0] MIN_SEC       = 34'd60;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_SUB,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        K_CYCLE,
        K_YEAR,
        K_MONTH,
        K_DAY,
        K_HOUR,
        K_MIN
    } t_ksel;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE  = 3'd0;
    localparam t_step ST_CYCLE = 3'd1;
    localparam t_step ST_YEAR  = 3'd2;
    localparam t_step ST_MONTH = 3'd3;
    localparam t_step ST_DAY   = 3'd4;
    localparam t_step ST_HOUR  = 3'd5;
    localparam t_step ST_MIN   = 3'd6;
    localparam t_step ST_EMIT  = 3'd7;

    typedef struct packed {
        t_op   op;
        t_ksel ksel;
        t_step next;
    } t_uword;

    typedef struct packed {
        logic  load;
        logic  sub;
        logic  emit;
        t_ksel ksel;
    } t_dp_ctl;

    typedef struct packed {
        logic less;
        logic out_free;
    } t_dp_stat;

    // microprogram: a SUB step repeats until the remainder drops below its constant
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_IDLE:  w = '{op: OP_WAIT, ksel: K_CYCLE, next: ST_CYCLE};
            ST_CYCLE: w = '{op: OP_SUB,  ksel: K_CYCLE, next: ST_YEAR};
            ST_YEAR:  w = '{op: OP_SUB,  ksel: K_YEAR,  next: ST_MONTH};
            ST_MONTH: w = '{op: OP_SUB,  ksel: K_MONTH, next: ST_DAY};
            ST_DAY:   w = '{op: OP_SUB,  ksel: K_DAY,   next: ST_HOUR};
            ST_HOUR:  w = '{op: OP_SUB,  ksel: K_HOUR,  next: ST_MIN};
            ST_MIN:   w = '{op: OP_SUB,  ksel: K_MIN,   next: ST_EMIT};
            ST_EMIT:  w = '{op: OP_EMIT, ksel: K_CYCLE, next: ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic is_leap(input logic [Y400_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != Y400_C100) && (y != Y400_C200) && (y != Y400_C300);
    endfunction

    function automatic logic [CONST_W-1:0] month_sec(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [CONST_W-1:0] v;
        unique case (m)
            4'd2:                      v = leap ? MON29_SEC : MON28_SEC;
            4'd4, 4'd6, 4'd9, 4'd11:   v = MON30_SEC;
            default:                   v = MON31_SEC;
        endcase
        return v;
    endfunction

endpackage

// ===== src/e2c_if.sv =====
// Stream interfaces for the timestamp input and the calendar result.
interface e2c_in_if #(
    parameter int SW = e2c_pkg::SECONDS_WIDTH_DEF
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if;
    logic                         valid;
    logic                         ready;
    logic [e2c_pkg::YEAR_W-1:0]   year;
    logic [e2c_pkg::MONTH_W-1:0]  month;
    logic [e2c_pkg::DAY_W-1:0]    day;
    logic [e2c_pkg::HOUR_W-1:0]   hour;
    logic [e2c_pkg::MIN_W-1:0]    minute;
    logic [e2c_pkg::SEC_W-1:0]    second;
    logic                         before_epoch;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, output before_epoch, input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, input before_epoch, output ready);
endinterface

// ===== src/epoch_seconds_to_calendar.sv =====
// Top level: epoch seconds to Gregorian date and time converter.
//
//  channel   direction  handshake        payload
//  i_in      in         valid/ready      epoch_seconds
//  o_out     out        valid/ready      year month day hour minute second before_epoch
//  apb       in/out     psel/penable     zone_offset_seconds at every byte address 0-3
//
// Each item is loaded at the first step, then passes through six subtract steps in order (whole
// 400-year cycles, years left after them, months, days, hours, minutes); each step makes one pass
// of the shared subtract-compare unit per whole unit it counts and leaves on the compare that
// finds the remainder below its constant. The emit step then registers the result once the output is free.
// Reset clears the step counter and the result valid, and sets the offset to 28800.
// i_in.ready is high only while the sequencer waits at its first step; a result held by a
// stalled sink blocks the emit step of the following transaction, which is still taken.
module epoch_seconds_to_calendar #(
    parameter int SECONDS_WIDTH = e2c_pkg::SECONDS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    e2c_in_if.sink      i_in,
    e2c_out_if.source   o_out
);
    import e2c_pkg::*;

    logic [ZONE_W-1:0] zone;
    t_dp_ctl           ctl;
    t_dp_stat          stat;
    logic              in_ready;

    assign i_in.ready = in_ready;

    e2c_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_zone  (zone)
    );

    e2c_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_in_ready (in_ready)
    );

    e2c_dp #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_secs         (i_in.epoch_seconds),
        .i_zone         (zone),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_out_ready    (o_out.ready),
        .o_valid        (o_out.valid),
        .o_year         (o_out.year),
        .o_month        (o_out.month),
        .o_day          (o_out.day),
        .o_hour         (o_out.hour),
        .o_minute       (o_out.minute),
        .o_second       (o_out.second),
        .o_before_epoch (o_out.before_epoch)
    );

endmodule

// ===== src/e2c_cfg.sv =====
// APB register holding the time-zone offset.
module e2c_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [e2c_pkg::ZONE_W-1:0]  o_zone
);
    import e2c_pkg::*;

    logic [ZONE_W-1:0] r_zone;
    logic              wr_en;

    // single register: every address in the window maps to it
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
    assign pready = 1'b1;
    assign prdata = {{(32-ZONE_W){1'b0}}, r_zone};
    assign o_zone = r_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (wr_en) begin
            r_zone <= pwdata[ZONE_W-1:0];
        end
    end

endmodule

// ===== src/e2c_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module e2c_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  e2c_pkg::t_dp_stat i_stat,
    output e2c_pkg::t_dp_ctl  o_ctl,
    output logic              o_in_ready
);
    import e2c_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w;

    assign w          = ucode(r_step);
    assign o_in_ready = (w.op == OP_WAIT);

    always_comb begin
        n_step     = r_step;
        o_ctl.load = 1'b0;
        o_ctl.sub  = 1'b0;
        o_ctl.emit = 1'b0;
        o_ctl.ksel = w.ksel;
        unique case (w.op)
            OP_WAIT: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_step     = w.next;
                end
            end
            OP_SUB: begin
                if (i_stat.less) begin
                    n_step = w.next;
                end else begin
                    o_ctl.sub = 1'b1;
                end
            end
            OP_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_step     = w.next;
                end
            end
            default: n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== src/e2c_dp.sv =====
// Datapath: zone adjust and clamp, subtract-compare unit, field counters, result register.
module e2c_dp #(
    parameter int SECONDS_WIDTH = e2c_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [SECONDS_WIDTH-1:0]     i_secs,
    input  logic [e2c_pkg::ZONE_W-1:0]   i_zone,
    input  e2c_pkg::t_dp_ctl             i_ctl,
    output e2c_pkg::t_dp_stat            o_stat,
    input  logic                         i_out_ready,
    output logic                         o_valid,
    output logic [e2c_pkg::YEAR_W-1:0]   o_year,
    output logic [e2c_pkg::MONTH_W-1:0]  o_month,
    output logic [e2c_pkg::DAY_W-1:0]    o_day,
    output logic [e2c_pkg::HOUR_W-1:0]   o_hour,
    output logic [e2c_pkg::MIN_W-1:0]    o_minute,
    output logic [e2c_pkg::SEC_W-1:0]    o_second,
    output logic                         o_before_epoch
);
    import e2c_pkg::*;

    localparam int SW = SECONDS_WIDTH;
    localparam int TW = SW + 1;
    localparam int DW = (TW > CONST_W) ? TW : CONST_W;
    localparam longint unsigned YEAR_SPAN =
        ((64'd1 << SW) + 64'd50400) / 64'd31536000 + 64'd2;
    localparam int YW_MIN = $clog2(64'd1970 + YEAR_SPAN + 64'd1);
    localparam int YW = (YW_MIN > YEAR_W) ? YW_MIN : YEAR_W;

    logic [SW+1:0]     adj;
    logic              neg;
    logic [DW-1:0]     t_load;
    logic [DW-1:0]     k;
    logic [DW:0]       diff;
    logic              leap;
    logic [YEAR_W-1:0] year_sat;

    logic [DW-1:0]     r_t;
    logic [YW-1:0]     r_year;
    logic [Y400_W-1:0] r_y400;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]  r_day;
    logic [HOUR_W-1:0] r_hour;
    logic [MIN_W-1:0]  r_min;
    logic              r_before;

    logic              r_o_valid;
    logic [YEAR_W-1:0] r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [DAY_W-1:0]  r_o_day;
    logic [HOUR_W-1:0] r_o_hour;
    logic [MIN_W-1:0]  r_o_min;
    logic [SEC_W-1:0]  r_o_sec;
    logic              r_o_before;

    assign adj    = {2'b00, i_secs} + {{(SW+2-ZONE_W){i_zone[ZONE_W-1]}}, i_zone};
    assign neg    = adj[SW+1];
    assign t_load = neg ? '0 : DW'(adj[SW:0]);
    assign leap   = is_leap(r_y400);

    always_comb begin
        unique case (i_ctl.ksel)
            K_CYCLE: k = DW'(CYCLE_SEC);
            K_YEAR:  k = leap ? DW'(LEAP_YEAR_SEC) : DW'(YEAR_SEC);
            K_MONTH: k = DW'(month_sec(r_month, leap));
            K_DAY:   k = DW'(DAY_SEC);
            K_HOUR:  k = DW'(HOUR_SEC);
            K_MIN:   k = DW'(MIN_SEC);
            default: k = DW'(DAY_SEC);
        endcase
    end

    assign diff = {1'b0, r_t} - {1'b0, k};

    assign o_stat.less     = diff[DW];
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign year_sat = (r_year > YW'(YEAR_MAX)) ? YEAR_MAX : r_year[YEAR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_t      <= t_load;
            r_year   <= YW'(EPOCH_YEAR);
            r_y400   <= EPOCH_Y400;
            r_month  <= MONTH_W'(1);
            r_day    <= DAY_W'(1);
            r_hour   <= '0;
            r_min    <= '0;
            r_before <= neg;
        end else if (i_ctl.sub) begin
            r_t <= diff[DW-1:0];
            unique case (i_ctl.ksel)
                K_CYCLE: r_year <= r_year + YW'(CYCLE_YEARS);
                K_YEAR: begin
                    r_year <= r_year + YW'(1);
                    r_y400 <= (r_y400 == Y400_LAST) ? '0 : r_y400 + Y400_W'(1);
                end
                K_MONTH: r_month <= r_month + MONTH_W'(1);
                K_DAY:   r_day   <= r_day + DAY_W'(1);
                K_HOUR:  r_hour  <= r_hour + HOUR_W'(1);
                K_MIN:   r_min   <= r_min + MIN_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_o_year   <= year_sat;
            r_o_month  <= r_month;
            r_o_day    <= r_day;
            r_o_hour   <= r_hour;
            r_o_min    <= r_min;
            r_o_sec    <= r_t[SEC_W-1:0];
            r_o_before <= r_before;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_year         = r_o_year;
    assign o_month        = r_o_month;
    assign o_day          = r_o_day;
    assign o_hour         = r_o_hour;
    assign o_minute       = r_o_min;
    assign o_second       = r_o_sec;
    assign o_before_epoch = r_o_before;

endmodule

// ===== src/e2c_chk.sv =====
// Port-level checker for the converter, bound to the top level.
module e2c_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [e2c_pkg::YEAR_W-1:0]  i_year,
    input logic [e2c_pkg::MONTH_W-1:0] i_month,
    input logic [e2c_pkg::DAY_W-1:0]   i_day,
    input logic [e2c_pkg::HOUR_W-1:0]  i_hour,
    input logic [e2c_pkg::MIN_W-1:0]   i_minute,
    input logic [e2c_pkg::SEC_W-1:0]   i_second,
    input logic                        i_before
);
    import e2c_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_year, i_month, i_day, i_hour, i_minute, i_second, i_before}))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after a transaction");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_month >= 4'd1) && (i_month <= 4'd12) && (i_day >= 5'd1) &&
        (i_hour <= 5'd23) && (i_minute <= 6'd59) && (i_second <= 6'd59) &&
        (i_year >= EPOCH_YEAR))
        else $error("result field out of range");

    a_clamp_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_before |-> (i_year == EPOCH_YEAR) && (i_month == 4'd1) &&
        (i_day == 5'd1) && (i_hour == 5'd0) && (i_minute == 6'd0) && (i_second == 6'd0))
        else $error("clamped result is not the epoch");

endmodule

bind epoch_seconds_to_calendar e2c_chk u_e2c_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_year      (o_out.year),
    .i_month     (o_out.month),
    .i_day       (o_out.day),
    .i_hour      (o_out.hour),
    .i_minute    (o_out.minute),
    .i_second    (o_out.second),
    .i_before    (o_out.before_epoch)
);

// ===== tb/sv/e2c_calendar_check.sv =====
`timescale 1ns / 100ps
// Result checker for the epoch converter: predicts each date from the stamp and zone offset.
module e2c_calendar_check #(
    parameter logic [1:0] ZONE_ADDR = 2'd0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [1:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic                          i_stamp_valid,
    input  logic                          i_stamp_ready,
    input  logic [31:0]                   i_stamp,
    input  logic                          i_date_valid,
    input  logic                          i_date_ready,
    input  logic [e2c_pkg::YEAR_W-1:0]    i_year,
    input  logic [e2c_pkg::MONTH_W-1:0]   i_month,
    input  logic [e2c_pkg::DAY_W-1:0]     i_day,
    input  logic [e2c_pkg::HOUR_W-1:0]    i_hour,
    input  logic [e2c_pkg::MIN_W-1:0]     i_minute,
    input  logic [e2c_pkg::SEC_W-1:0]     i_second,
    input  logic                          i_before_epoch,
    output int                            o_mismatches,
    output int                            o_owed
);
    import e2c_pkg::*;

    localparam longint SEC_PER_MIN  = 60;
    localparam longint SEC_PER_HOUR = 3600;
    localparam longint SEC_PER_DAY  = 86400;
    localparam longint DAYS_PER_ERA = 146097;

    typedef struct packed {
        logic [e2c_pkg::YEAR_W-1:0]  year;
        logic [e2c_pkg::MONTH_W-1:0] month;
        logic [e2c_pkg::DAY_W-1:0]   day;
        logic [e2c_pkg::HOUR_W-1:0]  hour;
        logic [e2c_pkg::MIN_W-1:0]   minute;
        logic [e2c_pkg::SEC_W-1:0]   second;
        logic                        before_epoch;
    } t_date;

    t_date                              pending_dates[$];
    logic signed [e2c_pkg::ZONE_W-1:0]  zone_offset;

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic t_date to_calendar(input logic [31:0] stamp,
                                          input logic signed [e2c_pkg::ZONE_W-1:0] zone);
        longint      wall_sec;
        longint      day_count;
        longint      day_sec;
        int unsigned yr;
        int unsigned mon;
        t_date       d;
        wall_sec = longint'({32'd0, stamp}) + longint'(zone);
        d.before_epoch = (wall_sec < 0);
        if (wall_sec < 0) wall_sec = 0;
        day_count = wall_sec / SEC_PER_DAY;
        day_sec   = wall_sec % SEC_PER_DAY;
        // whole 400-year eras all have the same length
        yr = 32'(longint'(EPOCH_YEAR) + 400 * (day_count / DAYS_PER_ERA));
        day_count = day_count % DAYS_PER_ERA;
        while (day_count >= days_in_year(yr)) begin
            day_count -= days_in_year(yr);
            yr++;
        end
        for (mon = 1; mon < 12 && day_count >= days_in_month(mon, yr); mon++)
            day_count -= days_in_month(mon, yr);
        if (yr > 32'(YEAR_MAX)) yr = 32'(YEAR_MAX);
        d.year   = yr[YEAR_W-1:0];
        d.month  = mon[MONTH_W-1:0];
        d.day    = DAY_W'(day_count + 1);
        d.hour   = HOUR_W'(day_sec / SEC_PER_HOUR);
        d.minute = MIN_W'((day_sec % SEC_PER_HOUR) / SEC_PER_MIN);
        d.second = SEC_W'(day_sec % SEC_PER_MIN);
        return d;
    endfunction

    function automatic string date_text(input t_date d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d before_epoch=%0d", d.year, d.month, d.day,
                         d.hour, d.minute, d.second, d.before_epoch);
    endfunction

    always @(posedge i_clk) begin : watch
        t_date got;
        t_date want;
        string bad;
        if (!i_rst_n) begin
            pending_dates.delete();
            zone_offset = e2c_pkg::ZONE_RESET;
            o_mismatches <= 0;
            o_owed <= 0;
        end else begin
            if (i_stamp_valid && i_stamp_ready)
                pending_dates.push_back(to_calendar(i_stamp, zone_offset));
            if (i_date_valid && i_date_ready) begin
                got = '{year: i_year, month: i_month, day: i_day, hour: i_hour,
                        minute: i_minute, second: i_second, before_epoch: i_before_epoch};
                if (pending_dates.size() == 0) begin
                    $display("%0t: date %s arrived, expected none", $time, date_text(got));
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = pending_dates.pop_front();
                    bad = "";
                    if (got.year !== want.year) bad = {bad, " year"};
                    if (got.month !== want.month) bad = {bad, " month"};
                    if (got.day !== want.day) bad = {bad, " day"};
                    if (got.hour !== want.hour) bad = {bad, " hour"};
                    if (got.minute !== want.minute) bad = {bad, " minute"};
                    if (got.second !== want.second) bad = {bad, " second"};
                    if (got.before_epoch !== want.before_epoch) bad = {bad, " before_epoch"};
                    if (bad != "") begin
                        $display("%0t: date mismatch in%s: expected %s, got %s", $time, bad,
                                 date_text(want), date_text(got));
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ZONE_ADDR)
                zone_offset = i_pwdata[e2c_pkg::ZONE_W-1:0];
            o_owed <= pending_dates.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the epoch converter: clock, reset, stimulus, zone writes and verdict.
module tb;
    import e2c_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_STAMPS  = 250;
    localparam int PROBES        = 22;

    localparam logic [1:0]                  ZONE_ADDR     = 2'd0;
    localparam logic [e2c_pkg::ZONE_W-1:0]  ZONE_WEST     = -17'sd43200;
    localparam logic [e2c_pkg::ZONE_W-1:0]  ZONE_EAST     = 17'd50400;
    localparam logic [e2c_pkg::ZONE_W-1:0]  ZONE_UTC      = 17'd0;
    localparam logic [e2c_pkg::ZONE_W-1:0]  ZONE_MOST_NEG = 17'h10000;
    localparam logic [e2c_pkg::ZONE_W-1:0]  ZONE_MOST_POS = 17'h0FFFF;

    typedef enum {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} t_flow;

    typedef struct packed {
        logic [e2c_pkg::ZONE_W-1:0] zone;
        logic [31:0]                stamp;
    } t_probe;

    // leap days, year ends, century rule, clamping and the ends of the stamp range
    t_probe probes [PROBES] = '{
        {e2c_pkg::ZONE_RESET, 32'd0},
        {e2c_pkg::ZONE_RESET, 32'hFFFF_FFFF},
        {e2c_pkg::ZONE_RESET, 32'd951811199},
        {ZONE_UTC, 32'd0},
        {ZONE_UTC, 32'd86399},
        {ZONE_UTC, 32'd68169600},
        {ZONE_UTC, 32'd94694399},
        {ZONE_UTC, 32'd951782400},
        {ZONE_UTC, 32'd978307199},
        {ZONE_UTC, 32'd4107542399},
        {ZONE_UTC, 32'd4107542400},
        {ZONE_UTC, 32'h7FFF_FFFF},
        {ZONE_UTC, 32'h8000_0000},
        {ZONE_UTC, 32'hFFFF_FFFF},
        {ZONE_WEST, 32'd0},
        {ZONE_WEST, 32'd43199},
        {ZONE_WEST, 32'd43200},
        {ZONE_WEST, 32'hFFFF_FFFF},
        {ZONE_EAST, 32'd0},
        {ZONE_EAST, 32'hFFFF_FFFF},
        {ZONE_MOST_NEG, 32'd65535},
        {ZONE_MOST_NEG, 32'd65536}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [1:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic [e2c_pkg::ZONE_W-1:0]  zone_now;
    int                          send_gap_pct;
    int                          recv_stall_pct;
    int                          hold_requests;
    int                          mismatches;
    int                          owed;

    e2c_in_if #(.SW(e2c_pkg::SECONDS_WIDTH_DEF)) stamp_ch ();
    e2c_out_if date_ch ();

    epoch_seconds_to_calendar #(
        .SECONDS_WIDTH(e2c_pkg::SECONDS_WIDTH_DEF)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (stamp_ch),
        .o_out   (date_ch)
    );

    e2c_calendar_check #(
        .ZONE_ADDR(ZONE_ADDR)
    ) date_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_stamp_valid  (stamp_ch.valid),
        .i_stamp_ready  (stamp_ch.ready),
        .i_stamp        (stamp_ch.epoch_seconds),
        .i_date_valid   (date_ch.valid),
        .i_date_ready   (date_ch.ready),
        .i_year         (date_ch.year),
        .i_month        (date_ch.month),
        .i_day          (date_ch.day),
        .i_hour         (date_ch.hour),
        .i_minute       (date_ch.minute),
        .i_second       (date_ch.second),
        .i_before_epoch (date_ch.before_epoch),
        .o_mismatches   (mismatches),
        .o_owed         (owed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_stamp(input logic [31:0] stamp);
        while ($urandom_range(99) < send_gap_pct) begin
            stamp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        stamp_ch.valid <= 1'b1;
        stamp_ch.epoch_seconds <= stamp;
        do @(posedge i_clk); while (!stamp_ch.ready);
    endtask

    // stop offering and wait for every outstanding date
    task automatic settle();
        stamp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
    endtask

    task automatic write_zone(input logic [e2c_pkg::ZONE_W-1:0] zone);
        logic [31:0] word;
        word = $urandom;
        word[e2c_pkg::ZONE_W-1:0] = zone;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ZONE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        zone_now = zone;
    endtask

    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        date_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                date_ch.ready <= 1'b0;
            end else begin
                date_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int unsigned sel;
        logic [31:0] stamp;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ZONE_ADDR;
        pwdata  = '0;
        stamp_ch.valid = 1'b0;
        stamp_ch.epoch_seconds = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        zone_now = e2c_pkg::ZONE_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[i]) begin
            if (probes[i].zone != zone_now) begin
                settle();
                write_zone(probes[i].zone);
            end
            send_stamp(probes[i].stamp);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                0:       write_zone(ZONE_WEST);
                1:       write_zone(ZONE_EAST);
                2:       write_zone(ZONE_UTC);
                3:       write_zone(ZONE_MOST_NEG);
                4:       write_zone(ZONE_MOST_POS);
                5:       write_zone(ZONE_W'($urandom));
                default: write_zone(ZONE_W'($urandom_range(93600) - 43200));
            endcase
            case (t_flow'(phase % 4))
                FLOW_FREE:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                FLOW_SEND_GAPS:   begin send_gap_pct = 62; recv_stall_pct = 0;  end
                FLOW_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 62; end
                default:          begin send_gap_pct = 27; recv_stall_pct = 27; end
            endcase
            // long receiver hold-off so the converter backs up into its input
            if (phase == 0) hold_requests++;
            repeat (PHASE_STAMPS) begin
                sel = $urandom_range(99);
                if (sel < 55)
                    stamp = $urandom;
                else if (sel < 70)
                    stamp = $urandom_range(200000);
                else if (sel < 80)
                    stamp = 32'hFFFF_FFFF - $urandom_range(200000);
                else
                    stamp = 32'd86400 * $urandom_range(49709)
                            + ($urandom_range(1) ? 32'd86399 : 32'd0);
                send_stamp(stamp);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== epoch_seconds_to_calendar.f =====
src/e2c_pkg.sv
src/e2c_if.sv
src/e2c_cfg.sv
src/e2c_useq.sv
src/e2c_dp.sv
src/epoch_seconds_to_calendar.sv
src/e2c_chk.sv
tb/sv/e2c_calendar_check.sv
tb/sv/tb.sv
